// ----- src/pwm_light_fader_with_curve_macros.svh -----
// Assertion macros for the light fader checker.
// Both sample on the rising edge of clk and are disabled while rst is high.

`ifndef PWM_LIGHT_FADER_WITH_CURVE_MACROS_SVH
`define PWM_LIGHT_FADER_WITH_CURVE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PLF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PLF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/plf_pkg.sv -----
// Shared types, constants and tables for the light fader.
// Used by the sequencer, datapath, duty mapper and top level; depends on nothing.
`timescale 1ns / 1ps

package plf_pkg;

  localparam int PC_W       = 5;
  localparam int LEVEL_W    = 7;
  localparam int ELAPSED_W  = 16;
  localparam int FADE_W     = 17;
  localparam int CURVE_W    = 4;
  localparam int CHAN_W     = 3;
  localparam int DUTY_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int TDATA_W    = 24;
  localparam int BLEND_W    = 24;
  localparam int DIVISOR_W  = 17;

  localparam logic [LEVEL_W-1:0] MAX_LEVEL = 7'd100;
  localparam logic [DUTY_W-1:0]  MAX_DUTY  = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_FADE_MILLIS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL     = 2'd2;

  localparam logic [CURVE_W-1:0] CURVE_LINEAR = 4'd0;
  localparam logic [CURVE_W-1:0] CURVE_BLEND  = 4'd2;

  // Reciprocal of 100 scaled by 2^22, rounded up; exact for numerators below 2^15.
  localparam logic [30:0] RECIP_100   = 31'd41944;
  localparam int          RECIP_SHIFT = 22;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_SET_TARGET,
    OP_DIFF,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SET_STEP,
    OP_JUMP_LEVEL,
    OP_MUL_INIT,
    OP_MUL_STEP,
    OP_CLAMP,
    OP_BLEND_INIT,
    OP_OUT_LOAD
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_TICK,
    C_REQ_EQ_REP,
    C_FADE_ZERO,
    C_DIFF_LE_EPS,
    C_DIFF_LT_EPS,
    C_CNT_NZ,
    C_NOT_BLEND,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic tick;
    logic req_eq_rep;
    logic fade_zero;
    logic diff_le_eps;
    logic diff_lt_eps;
    logic cnt_nz;
    logic not_blend;
    logic out_busy;
  } status_t;

  // Q8 of 256^(v/100) - 1 for v = 0..100.
  localparam logic [15:0] EXP_Q8 [101] = '{
    16'd0,     16'd15,    16'd30,    16'd46,    16'd64,
    16'd82,    16'd101,   16'd121,   16'd143,   16'd166,
    16'd190,   16'd215,   16'd242,   16'd270,   16'd300,
    16'd332,   16'd366,   16'd401,   16'd439,   16'd478,
    16'd520,   16'd564,   16'd611,   16'd661,   16'd713,
    16'd768,   16'd826,   16'd888,   16'd953,   16'd1022,
    16'd1095,  16'd1172,  16'd1254,  16'd1340,  16'd1431,
    16'd1527,  16'd1629,  16'd1736,  16'd1850,  16'd1970,
    16'd2097,  16'd2231,  16'd2372,  16'd2522,  16'd2681,
    16'd2848,  16'd3025,  16'd3212,  16'd3410,  16'd3619,
    16'd3840,  16'd4074,  16'd4320,  16'd4581,  16'd4857,
    16'd5149,  16'd5457,  16'd5783,  16'd6127,  16'd6491,
    16'd6876,  16'd7282,  16'd7712,  16'd8166,  16'd8647,
    16'd9154,  16'd9691,  16'd10258, 16'd10857, 16'd11491,
    16'd12161, 16'd12869, 16'd13617, 16'd14408, 16'd15244,
    16'd16128, 16'd17062, 16'd18050, 16'd19093, 16'd20197,
    16'd21363, 16'd22595, 16'd23898, 16'd25276, 16'd26731,
    16'd28270, 16'd29897, 16'd31616, 16'd33433, 16'd35354,
    16'd37385, 16'd39531, 16'd41799, 16'd44197, 16'd46732,
    16'd49411, 16'd52243, 16'd55236, 16'd58400, 16'd61745,
    16'd65280
  };

endpackage

// ----- src/plf_seq.sv -----
// Microcode sequencer: step counter, control-word ROM and conditional jumps.
// Depends on plf_pkg for the control word, micro-op and status types.
`timescale 1ns / 1ps

module plf_seq (
  input  logic              clk,
  input  logic              rst,
  input  plf_pkg::status_t  status,
  output plf_pkg::op_t      op
);

  localparam logic [plf_pkg::PC_W-1:0] A_IDLE      = 5'd0;
  localparam logic [plf_pkg::PC_W-1:0] A_DISPATCH  = 5'd1;
  localparam logic [plf_pkg::PC_W-1:0] A_REQ_CMP   = 5'd2;
  localparam logic [plf_pkg::PC_W-1:0] A_REQ_TGT   = 5'd3;
  localparam logic [plf_pkg::PC_W-1:0] A_REQ_DIFF  = 5'd4;
  localparam logic [plf_pkg::PC_W-1:0] A_REQ_CHK   = 5'd5;
  localparam logic [plf_pkg::PC_W-1:0] A_REQ_DIVI  = 5'd6;
  localparam logic [plf_pkg::PC_W-1:0] A_REQ_DIV   = 5'd7;
  localparam logic [plf_pkg::PC_W-1:0] A_REQ_STEP  = 5'd8;
  localparam logic [plf_pkg::PC_W-1:0] A_JUMP      = 5'd9;
  localparam logic [plf_pkg::PC_W-1:0] A_TICK_DIFF = 5'd10;
  localparam logic [plf_pkg::PC_W-1:0] A_TICK_CHK  = 5'd11;
  localparam logic [plf_pkg::PC_W-1:0] A_MUL_INIT  = 5'd12;
  localparam logic [plf_pkg::PC_W-1:0] A_MUL       = 5'd13;
  localparam logic [plf_pkg::PC_W-1:0] A_CLAMP     = 5'd14;
  localparam logic [plf_pkg::PC_W-1:0] A_EMIT      = 5'd15;
  localparam logic [plf_pkg::PC_W-1:0] A_BLEND_INI = 5'd16;
  localparam logic [plf_pkg::PC_W-1:0] A_BLEND_DIV = 5'd17;
  localparam logic [plf_pkg::PC_W-1:0] A_OUT       = 5'd18;
  localparam logic [plf_pkg::PC_W-1:0] A_DONE      = 5'd19;

  logic [plf_pkg::PC_W-1:0] pc;
  logic [plf_pkg::PC_W-1:0] pc_next;
  plf_pkg::uword_t          cw;
  logic                     take;

  function automatic plf_pkg::uword_t uw(input plf_pkg::op_t o, input plf_pkg::cond_t c,
                                         input logic [plf_pkg::PC_W-1:0] t);
    plf_pkg::uword_t w;
    w.op     = o;
    w.cond   = c;
    w.target = t;
    return w;
  endfunction

  // The program. A step jumps to its target when its condition holds, else falls through.
  function automatic plf_pkg::uword_t rom(input logic [plf_pkg::PC_W-1:0] a);
    plf_pkg::uword_t w;
    case (a)
      A_IDLE:      w = uw(plf_pkg::OP_ACCEPT,     plf_pkg::C_NO_INPUT,    A_IDLE);
      A_DISPATCH:  w = uw(plf_pkg::OP_NOP,        plf_pkg::C_TICK,        A_TICK_DIFF);
      A_REQ_CMP:   w = uw(plf_pkg::OP_NOP,        plf_pkg::C_REQ_EQ_REP,  A_EMIT);
      A_REQ_TGT:   w = uw(plf_pkg::OP_SET_TARGET, plf_pkg::C_FADE_ZERO,   A_JUMP);
      A_REQ_DIFF:  w = uw(plf_pkg::OP_DIFF,       plf_pkg::C_NEVER,       A_IDLE);
      A_REQ_CHK:   w = uw(plf_pkg::OP_NOP,        plf_pkg::C_DIFF_LE_EPS, A_IDLE);
      A_REQ_DIVI:  w = uw(plf_pkg::OP_DIV_INIT,   plf_pkg::C_NEVER,       A_IDLE);
      A_REQ_DIV:   w = uw(plf_pkg::OP_DIV_STEP,   plf_pkg::C_CNT_NZ,      A_REQ_DIV);
      A_REQ_STEP:  w = uw(plf_pkg::OP_SET_STEP,   plf_pkg::C_ALWAYS,      A_IDLE);
      A_JUMP:      w = uw(plf_pkg::OP_JUMP_LEVEL, plf_pkg::C_ALWAYS,      A_EMIT);
      A_TICK_DIFF: w = uw(plf_pkg::OP_DIFF,       plf_pkg::C_NEVER,       A_IDLE);
      A_TICK_CHK:  w = uw(plf_pkg::OP_NOP,        plf_pkg::C_DIFF_LT_EPS, A_IDLE);
      A_MUL_INIT:  w = uw(plf_pkg::OP_MUL_INIT,   plf_pkg::C_NEVER,       A_IDLE);
      A_MUL:       w = uw(plf_pkg::OP_MUL_STEP,   plf_pkg::C_CNT_NZ,      A_MUL);
      A_CLAMP:     w = uw(plf_pkg::OP_CLAMP,      plf_pkg::C_NEVER,       A_IDLE);
      A_EMIT:      w = uw(plf_pkg::OP_NOP,        plf_pkg::C_NOT_BLEND,   A_OUT);
      A_BLEND_INI: w = uw(plf_pkg::OP_BLEND_INIT, plf_pkg::C_NEVER,       A_IDLE);
      A_BLEND_DIV: w = uw(plf_pkg::OP_DIV_STEP,   plf_pkg::C_CNT_NZ,      A_BLEND_DIV);
      A_OUT:       w = uw(plf_pkg::OP_OUT_LOAD,   plf_pkg::C_OUT_BUSY,    A_OUT);
      A_DONE:      w = uw(plf_pkg::OP_NOP,        plf_pkg::C_ALWAYS,      A_IDLE);
      default:     w = uw(plf_pkg::OP_NOP,        plf_pkg::C_ALWAYS,      A_IDLE);
    endcase
    return w;
  endfunction

  assign cw = rom(pc);
  assign op = cw.op;

  always_comb begin
    case (cw.cond)
      plf_pkg::C_NEVER:       take = 1'b0;
      plf_pkg::C_ALWAYS:      take = 1'b1;
      plf_pkg::C_NO_INPUT:    take = !status.in_valid;
      plf_pkg::C_TICK:        take = status.tick;
      plf_pkg::C_REQ_EQ_REP:  take = status.req_eq_rep;
      plf_pkg::C_FADE_ZERO:   take = status.fade_zero;
      plf_pkg::C_DIFF_LE_EPS: take = status.diff_le_eps;
      plf_pkg::C_DIFF_LT_EPS: take = status.diff_lt_eps;
      plf_pkg::C_CNT_NZ:      take = status.cnt_nz;
      plf_pkg::C_NOT_BLEND:   take = status.not_blend;
      plf_pkg::C_OUT_BUSY:    take = status.out_busy;
      default:                take = 1'b0;
    endcase
    pc_next = take ? cw.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= A_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ----- src/plf_duty.sv -----
// Duty mapper: linear and exponential duty of an integer level, and the
// operands of the blend division. Depends on plf_pkg for widths and the curve table.
`timescale 1ns / 1ps

module plf_duty (
  input  logic [plf_pkg::LEVEL_W-1:0]   level,
  input  logic [plf_pkg::CURVE_W-1:0]   curve_mode,
  output logic [plf_pkg::DUTY_W-1:0]    direct_duty,
  output logic [plf_pkg::BLEND_W-1:0]   blend_dividend,
  output logic [plf_pkg::DIVISOR_W-1:0] blend_divisor
);

  logic [15:0]                  exp_q8;
  logic [14:0]                  lin_num;
  logic [30:0]                  lin_prod;
  logic [plf_pkg::DUTY_W-1:0]   lin_duty;
  logic [plf_pkg::CURVE_W-1:0]  curve_m1;
  logic [18:0]                  lin_q;
  logic [22:0]                  lin_part;
  logic [22:0]                  num;
  logic [14:0]                  den;

  assign exp_q8 = (level > plf_pkg::MAX_LEVEL) ? 16'd0 : plf_pkg::EXP_Q8[level];

  // floor(v * 255 / 100) through a reciprocal multiply.
  assign lin_num     = 15'(level) * 15'd255;
  assign lin_prod    = 31'(lin_num) * plf_pkg::RECIP_100;
  assign lin_duty    = plf_pkg::DUTY_W'(lin_prod >> plf_pkg::RECIP_SHIFT);
  assign direct_duty = (curve_mode == plf_pkg::CURVE_LINEAR) ? lin_duty : exp_q8[15:8];

  // Blend in units of 1/1280: 5*E[v] + 3264*v*(c-1) over 1280*c, rounded half up
  // as (2*num + den) / (2*den).
  assign curve_m1       = curve_mode - 1'b1;
  assign lin_q          = 19'(level) * 19'd3264;
  assign lin_part       = 23'(lin_q) * 23'(curve_m1);
  assign num            = 23'(exp_q8) * 23'd5 + lin_part;
  assign den            = 15'(curve_mode) * 15'd1280;
  assign blend_dividend = {num, 1'b0} + plf_pkg::BLEND_W'(den);
  assign blend_divisor  = plf_pkg::DIVISOR_W'({den, 1'b0});

endmodule

// ----- src/plf_dp.sv -----
// Fader datapath: level state, shared restoring divider, shift-add multiplier,
// clamp logic and the output register. Driven by micro-ops; depends on plf_pkg.
`timescale 1ns / 1ps

module plf_dp #(
  parameter int FRAC_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst,
  input  plf_pkg::op_t                   op,
  input  logic                           in_valid,
  input  logic                           in_tick,
  input  logic [plf_pkg::LEVEL_W-1:0]    in_req,
  input  logic [plf_pkg::ELAPSED_W-1:0]  in_elapsed,
  input  logic [plf_pkg::FADE_W-1:0]     fade_millis,
  input  logic [plf_pkg::CURVE_W-1:0]    curve_mode,
  input  logic [plf_pkg::CHAN_W-1:0]     channel,
  input  logic [plf_pkg::DUTY_W-1:0]     direct_duty,
  input  logic [plf_pkg::BLEND_W-1:0]    blend_dividend,
  input  logic [plf_pkg::DIVISOR_W-1:0]  blend_divisor,
  input  logic                           out_ready,
  output logic [plf_pkg::LEVEL_W-1:0]    level,
  output plf_pkg::status_t               status,
  output logic                           out_valid,
  output logic [plf_pkg::CHAN_W-1:0]     out_channel,
  output logic [plf_pkg::DUTY_W-1:0]     out_duty,
  output logic [plf_pkg::LEVEL_W-1:0]    out_level
);

  localparam int LW = FRAC_BITS + plf_pkg::LEVEL_W;
  localparam int SW = LW + 1;
  localparam int DW = (LW > plf_pkg::BLEND_W) ? LW : plf_pkg::BLEND_W;
  localparam int PW = SW + plf_pkg::ELAPSED_W + 1;
  localparam int CW = $clog2(DW);
  localparam int RW = plf_pkg::DIVISOR_W;
  localparam longint EPS_INT = ((longint'(1) << FRAC_BITS) + 500) / 1000;
  localparam logic [LW-1:0]        EPS      = LW'(EPS_INT);
  localparam logic signed [PW-1:0] HUNDRED  = PW'(100) << FRAC_BITS;
  localparam logic [CW-1:0]        DIV_LAST = CW'(DW - 1);
  localparam logic [CW-1:0]        MUL_LAST = CW'(plf_pkg::ELAPSED_W - 1);

  // Item and level state.
  logic                          item_tick;
  logic [plf_pkg::LEVEL_W-1:0]   item_req;
  logic [plf_pkg::ELAPSED_W-1:0] item_elapsed;
  logic [plf_pkg::LEVEL_W-1:0]   target;
  logic [LW-1:0]                 current;
  logic signed [SW-1:0]          step;
  logic [plf_pkg::LEVEL_W-1:0]   reported;

  // Working registers.
  logic signed [SW-1:0]          diff;
  logic [DW-1:0]                 quo;
  logic [RW-1:0]                 rem;
  logic [RW-1:0]                 divisor;
  logic signed [PW-1:0]          acc;
  logic signed [PW-1:0]          mcand;
  logic [plf_pkg::ELAPSED_W-1:0] mplier;
  logic [CW-1:0]                 cnt;

  logic [plf_pkg::LEVEL_W-1:0]   req_sat;
  logic signed [SW-1:0]          tgt_s;
  logic signed [SW-1:0]          diff_calc;
  logic [LW-1:0]                 abs_diff;
  logic [RW:0]                   trial;
  logic                          fits;
  logic [RW:0]                   trial_sub;
  logic [LW-1:0]                 mag;
  logic signed [SW-1:0]          step_calc;
  logic signed [PW-1:0]          tgt_p;
  logic                          step_pos;
  logic signed [PW-1:0]          stop_val;
  logic signed [PW-1:0]          clamp_val;
  logic [plf_pkg::DUTY_W-1:0]    duty_sel;
  logic                          not_blend;
  logic                          out_busy;

  assign req_sat   = (in_req > plf_pkg::MAX_LEVEL) ? plf_pkg::MAX_LEVEL : in_req;
  assign tgt_s     = $signed({1'b0, target, {FRAC_BITS{1'b0}}});
  assign diff_calc = tgt_s - $signed({1'b0, current});
  assign abs_diff  = diff[SW-1] ? LW'(-diff) : diff[LW-1:0];

  // One restoring division step per cycle; the quotient shifts into quo.
  assign trial     = {rem, quo[DW-1]};
  assign fits      = trial >= {1'b0, divisor};
  assign trial_sub = trial - {1'b0, divisor};

  // Ramp step: |diff| / fade, raised to the minimum magnitude, signed like diff.
  assign mag       = (quo[LW-1:0] < EPS) ? EPS : quo[LW-1:0];
  assign step_calc = (!diff[SW-1] && (diff != '0)) ? $signed({1'b0, mag})
                                                    : -$signed({1'b0, mag});

  // Stop at the target in the ramp direction, then keep within 0..100.
  assign tgt_p     = $signed({{(PW - LW){1'b0}}, target, {FRAC_BITS{1'b0}}});
  assign step_pos  = !step[SW-1] && (step != '0);
  always_comb begin
    if (step_pos) begin
      stop_val = (acc > tgt_p) ? tgt_p : acc;
    end else begin
      stop_val = (acc < tgt_p) ? tgt_p : acc;
    end
    if (stop_val < 0) begin
      clamp_val = '0;
    end else if (stop_val > HUNDRED) begin
      clamp_val = HUNDRED;
    end else begin
      clamp_val = stop_val;
    end
  end

  assign level     = current[LW-1:FRAC_BITS];
  assign not_blend = curve_mode < plf_pkg::CURVE_BLEND;
  assign out_busy  = out_valid && !out_ready;
  assign duty_sel  = not_blend ? direct_duty
                   : ((quo > DW'(plf_pkg::MAX_DUTY)) ? plf_pkg::MAX_DUTY : quo[7:0]);

  always_comb begin
    status.in_valid    = in_valid;
    status.tick        = item_tick;
    status.req_eq_rep  = item_req == reported;
    status.fade_zero   = fade_millis == '0;
    status.diff_le_eps = abs_diff <= EPS;
    status.diff_lt_eps = abs_diff < EPS;
    status.cnt_nz      = cnt != '0;
    status.not_blend   = not_blend;
    status.out_busy    = out_busy;
  end

  // Architectural state and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      target    <= '0;
      current   <= '0;
      step      <= '0;
      reported  <= '0;
      out_valid <= 1'b0;
    end else begin
      // A new beat may be loaded in the cycle the previous one is taken.
      if ((op == plf_pkg::OP_OUT_LOAD) && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (op)
        plf_pkg::OP_SET_TARGET: begin
          target <= item_req;
        end
        plf_pkg::OP_SET_STEP: begin
          step <= step_calc;
        end
        plf_pkg::OP_JUMP_LEVEL: begin
          current  <= {item_req, {FRAC_BITS{1'b0}}};
          reported <= item_req;
        end
        plf_pkg::OP_CLAMP: begin
          current  <= clamp_val[LW-1:0];
          reported <= clamp_val[LW-1:FRAC_BITS];
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers and output payload.
  always_ff @(posedge clk) begin
    case (op)
      plf_pkg::OP_ACCEPT: begin
        if (in_valid) begin
          item_tick    <= in_tick;
          item_req     <= req_sat;
          item_elapsed <= in_elapsed;
        end
      end
      plf_pkg::OP_DIFF: begin
        diff <= diff_calc;
      end
      plf_pkg::OP_DIV_INIT: begin
        quo     <= DW'(abs_diff);
        rem     <= '0;
        divisor <= fade_millis;
        cnt     <= DIV_LAST;
      end
      plf_pkg::OP_BLEND_INIT: begin
        quo     <= DW'(blend_dividend);
        rem     <= '0;
        divisor <= blend_divisor;
        cnt     <= DIV_LAST;
      end
      plf_pkg::OP_DIV_STEP: begin
        rem <= fits ? trial_sub[RW-1:0] : trial[RW-1:0];
        quo <= {quo[DW-2:0], fits};
        cnt <= cnt - 1'b1;
      end
      plf_pkg::OP_MUL_INIT: begin
        acc    <= $signed({{(PW - LW){1'b0}}, current});
        mcand  <= $signed({{(PW - SW){step[SW-1]}}, step});
        mplier <= item_elapsed;
        cnt    <= MUL_LAST;
      end
      plf_pkg::OP_MUL_STEP: begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt    <= cnt - 1'b1;
      end
      plf_pkg::OP_OUT_LOAD: begin
        if (!out_busy) begin
          out_channel <= channel;
          out_duty    <= duty_sel;
          out_level   <= level;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- src/pwm_light_fader_with_curve.sv -----
// Top level of the light fader: configuration registers, sequencer, datapath and duty mapper.
// Depends on plf_pkg, plf_seq, plf_dp and plf_duty.
// A tick runs the 16-step shift-add multiplier and, with a blend curve, also the shared
// one-bit-per-cycle divider over D = max(FRAC_BITS + 7, 24) bits; a request that starts a
// ramp runs the divider once.
// One item is in work at a time; a finished result waits in the output register.
// Synchronous active-high reset clears the configuration and the level, target and step to zero.
`timescale 1ns / 1ps

module pwm_light_fader_with_curve #(
  parameter int FRAC_BITS = 20
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [plf_pkg::TDATA_W-1:0]      s_axis_tdata,   // level_request, elapsed_millis
  input  logic                             s_axis_tuser,   // operation
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [plf_pkg::TDATA_W-1:0]      m_axis_tdata,   // out_channel, duty, level_now
  input  logic                             cfg_we,
  input  logic [plf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [plf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [plf_pkg::FADE_W-1:0]     fade_millis;
  logic [plf_pkg::CURVE_W-1:0]    curve_mode;
  logic [plf_pkg::CHAN_W-1:0]     channel;

  plf_pkg::op_t                   op;
  plf_pkg::status_t               status;
  logic [plf_pkg::LEVEL_W-1:0]    level;
  logic [plf_pkg::DUTY_W-1:0]     direct_duty;
  logic [plf_pkg::BLEND_W-1:0]    blend_dividend;
  logic [plf_pkg::DIVISOR_W-1:0]  blend_divisor;
  logic [plf_pkg::CHAN_W-1:0]     out_channel;
  logic [plf_pkg::DUTY_W-1:0]     out_duty;
  logic [plf_pkg::LEVEL_W-1:0]    out_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_millis <= '0;
      curve_mode  <= '0;
      channel     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        plf_pkg::REG_FADE_MILLIS: fade_millis <= cfg_data[plf_pkg::FADE_W-1:0];
        plf_pkg::REG_CURVE_MODE:  curve_mode  <= cfg_data[plf_pkg::CURVE_W-1:0];
        plf_pkg::REG_CHANNEL:     channel     <= cfg_data[plf_pkg::CHAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = op == plf_pkg::OP_ACCEPT;

  plf_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  plf_duty u_duty (
    .level          (level),
    .curve_mode     (curve_mode),
    .direct_duty    (direct_duty),
    .blend_dividend (blend_dividend),
    .blend_divisor  (blend_divisor)
  );

  plf_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .in_valid       (s_axis_tvalid),
    .in_tick        (s_axis_tuser),
    .in_req         (s_axis_tdata[6:0]),
    .in_elapsed     (s_axis_tdata[22:7]),
    .fade_millis    (fade_millis),
    .curve_mode     (curve_mode),
    .channel        (channel),
    .direct_duty    (direct_duty),
    .blend_dividend (blend_dividend),
    .blend_divisor  (blend_divisor),
    .out_ready      (m_axis_tready),
    .level          (level),
    .status         (status),
    .out_valid      (m_axis_tvalid),
    .out_channel    (out_channel),
    .out_duty       (out_duty),
    .out_level      (out_level)
  );

  assign m_axis_tdata = {6'd0, out_level, out_duty, out_channel};

endmodule

// ----- src/plf_checker.sv -----
// Port-level checker for the light fader, attached to the top level by bind.
// Depends on the assertion macros in pwm_light_fader_with_curve_macros.svh.
`timescale 1ns / 1ps
`include "pwm_light_fader_with_curve_macros.svh"

module plf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  `PLF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")
  `PLF_ASSERT_SAME(a_level_range, m_axis_tvalid, m_axis_tdata[17:11] <= 7'd100, "reported level above 100")
  `PLF_ASSERT_SAME(a_dark_duty, m_axis_tvalid && (m_axis_tdata[17:11] == 7'd0), m_axis_tdata[10:3] == 8'd0, "nonzero duty at level zero")
  `PLF_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken before the first was processed")

endmodule

bind pwm_light_fader_with_curve plf_checker u_plf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
